[hdl/pwc_pkg.sv]
package pwc_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned WidthW = 32;

  // operation codes
  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_CAPTURE  = 1'b1;

  // a pending overflow only belongs to stamps taken just after the wrap
  localparam logic [TickW-1:0] PENDING_LIMIT = 16'h7FFF;

  typedef struct packed {
    logic             operation;
    logic [TickW-1:0] capture_ticks;
    logic             overflow_pending;
  } in_t;

  typedef struct packed {
    logic [WidthW-1:0] pulse_width;
    logic              width_kind;
  } out_t;

endpackage

[hdl/pwc_core.sv]
module pwc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pwc_pkg::in_t  in_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_data_i,
  input  logic          buf_full_i,
  output logic          res_valid_o,
  output pwc_pkg::out_t res_data_o
);

  pwc_pkg::in_t                   in_q;
  logic                           in_valid_q, in_valid_d;
  logic [pwc_pkg::TickW-1:0]      ovf_cnt_q, ovf_cnt_d;
  logic [pwc_pkg::WidthW-1:0]     prev_q, prev_d;
  logic                           level_q, level_d;
  logic                           have_prev_q, have_prev_d;
  logic                           accept;
  logic                           fire;
  logic                           is_capture;
  logic                           bump;
  logic [pwc_pkg::TickW-1:0]      upper;
  logic [pwc_pkg::WidthW-1:0]     stamp;

  // the input register only holds when the result buffer is full
  assign in_ready_o = !in_valid_q || !buf_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = in_valid_q && !buf_full_i;
  assign is_capture = (in_q.operation == pwc_pkg::OP_CAPTURE);

  assign bump  = in_q.overflow_pending && (in_q.capture_ticks < pwc_pkg::PENDING_LIMIT);
  assign upper = ovf_cnt_q + {{(pwc_pkg::TickW-1){1'b0}}, bump};
  assign stamp = {upper, in_q.capture_ticks};

  assign res_valid_o            = fire && is_capture && have_prev_q;
  assign res_data_o.pulse_width = stamp - prev_q;
  assign res_data_o.width_kind  = level_q;

  always_comb begin
    in_valid_d  = in_valid_q;
    ovf_cnt_d   = ovf_cnt_q;
    prev_d      = prev_q;
    level_d     = level_q;
    have_prev_d = have_prev_q;
    if (fire) begin
      in_valid_d = 1'b0;
      if (is_capture) begin
        prev_d      = stamp;
        have_prev_d = 1'b1;
        level_d     = !level_q;
      end else begin
        ovf_cnt_d = ovf_cnt_q + {{(pwc_pkg::TickW-1){1'b0}}, 1'b1};
      end
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
    if (cfg_valid_i) begin
      level_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      ovf_cnt_q   <= '0;
      prev_q      <= '0;
      level_q     <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      ovf_cnt_q   <= ovf_cnt_d;
      prev_q      <= prev_d;
      level_q     <= level_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

endmodule

[hdl/pwc_out_buf.sv]
module pwc_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pwc_pkg::out_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pwc_pkg::out_t out_data_o
);

  pwc_pkg::out_t main_q, main_d;
  pwc_pkg::out_t skid_q, skid_d;
  logic          main_v_q, main_v_d;
  logic          skid_v_q, skid_v_d;
  logic          pop;

  assign pop         = main_v_q && out_ready_i;
  assign full_o      = main_v_q && skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  // push never arrives while both entries hold a beat
  always_comb begin
    main_d   = main_q;
    skid_d   = skid_q;
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (pop || !main_v_q) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_d   = push_data_i;
        skid_v_d = push_i;
      end else begin
        main_d   = push_data_i;
        main_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = push_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

[hdl/pulse_width_capture.sv]
// channel | dir | handshake              | payload
// in      | in  | in_valid_i/in_ready_o  | pwc_pkg::in_t  (operation, stamp, pending flag)
// out     | out | out_valid_o/out_ready_i| pwc_pkg::out_t (pulse_width, width_kind)
// cfg     | in  | cfg_valid_i/cfg_ready_o| start_level bit, always ready
//
// One beat per cycle while the result buffer is not full; a capture result
// passes the input register and then the result buffer before it is on out.
// Stage: input register, then subtract/compare into a two-entry result buffer.
// in_ready_o drops only while the input register holds a beat and both buffer
// entries are full, so a stalled output still lets one more beat in.
// Reset clears the overflow count, previous stamp, level and first-edge flag.
module pulse_width_capture (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pwc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pwc_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  logic          buf_full;
  logic          res_valid;
  pwc_pkg::out_t res_data;

  assign cfg_ready_o = 1'b1;

  pwc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .buf_full_i  (buf_full),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  pwc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/pwc_checker.sv]
module pwc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input pwc_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pwc_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out payload changed while stalled");

  // a fresh result comes from an earlier capture beat taken into the input register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && (in_data_i.operation == pwc_pkg::OP_CAPTURE), 2))
    else $error("result without a capture beat");

  // input only backs up behind waiting results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind pulse_width_capture pwc_checker u_pwc_checker (.*);
